// ----- rtl/ffba_pkg.sv -----
// Shared types, codes and constants of the first-fit block allocator.
// Used by every module of the allocator except ffba_ram; depends on nothing.
package ffba_pkg;

  localparam int MAX_BLOCKS          = 64;
  // Powers of two: rounding is done with masks.
  localparam int PAGE_BYTES          = 4096;
  localparam int HEADER_BYTES        = 32;
  localparam int ALIGN_BYTES         = 16;
  localparam int MIN_REMAINDER_BYTES = 64;

  localparam logic [1:0] CMD_ALLOC      = 2'd0;
  localparam logic [1:0] CMD_ALLOC_PAGE = 2'd1;
  localparam logic [1:0] CMD_FREE       = 2'd2;
  localparam logic [1:0] CMD_INIT       = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_SPACE   = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic [0:0] REG_REGION_START = 1'b0;
  localparam logic [0:0] REG_REGION_BYTES = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] request_bytes;
    logic [31:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] data_address;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [33:0] needed;
    logic [33:0] grow_amt;
    logic        zero;
    logic        big;
    logic [31:0] free_address;
  } job_t;

  function automatic logic [33:0] ru_align(logic [33:0] v);
    return (v + 34'(ALIGN_BYTES - 1)) & ~34'(ALIGN_BYTES - 1);
  endfunction

  function automatic logic [33:0] ru_page(logic [33:0] v);
    return (v + 34'(PAGE_BYTES - 1)) & ~34'(PAGE_BYTES - 1);
  endfunction

  localparam logic [33:0] INIT_AMT =
    (34'(PAGE_BYTES + HEADER_BYTES) + 34'(PAGE_BYTES - 1)) & ~34'(PAGE_BYTES - 1);

endpackage

// ----- rtl/first_fit_block_allocator_unit.sv -----
// Top level of the first-fit block allocator: config registers and wiring.
// Depends on ffba_pkg, ffba_front, ffba_queue, ffba_back.
// Early answers come straight from idle and init takes one table write; an allocation walks the
//   table to the first fitting entry (a split adds steps; growth adds a second walk), a free walks to its entry.
// Throughput: one request in the back, three more wait in front; set by the one-read table RAM.
// Reset clears control state and slot bits; table contents stay undefined. Results cannot stall.
module first_fit_block_allocator_unit #(
  parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ffba_pkg::in_item_t  in_item,
  output logic                out_valid,
  output ffba_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [31:0]    start_r, bytes_r;
  logic           q_full, q_valid, push, pop;
  ffba_pkg::job_t push_job, pop_job;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ffba_pkg::REG_REGION_BYTES) ? bytes_r : start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      bytes_r <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == ffba_pkg::REG_REGION_START) begin
        start_r <= pwdata;
      end else begin
        bytes_r <= pwdata;
      end
    end
  end

  ffba_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  ffba_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .pop_job  (pop_job)
  );

  ffba_back #(.MAX_BLOCKS(MAX_BLOCKS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (pop_job),
    .pop       (pop),
    .cfg_start (start_r),
    .cfg_bytes (bytes_r),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- rtl/ffba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ffba_front.sv -----
// Front part: accepts requests, rounds sizes and classifies them.
// Depends on ffba_pkg; feeds ffba_queue.
module ffba_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ffba_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              push,
  output ffba_pkg::job_t    push_job
);

  logic        st_v_r, st_v_nxt;
  logic [1:0]  cmd_r;
  logic [33:0] needed_r;
  logic        zero_r, big_r;
  logic [31:0] faddr_r;
  logic [33:0] sz, needed;
  logic        accept;

  assign busy   = st_v_r & q_full;
  assign push   = st_v_r & ~q_full;
  assign accept = start & ~busy;
  assign st_v_nxt = accept | (st_v_r & ~push);

  always_comb begin
    if (in_item.command == ffba_pkg::CMD_ALLOC_PAGE) begin
      sz = ffba_pkg::ru_page({2'b00, in_item.request_bytes});
    end else begin
      sz = {2'b00, in_item.request_bytes};
    end
    needed = ffba_pkg::ru_align(sz);
  end

  always_comb begin
    push_job.command      = cmd_r;
    push_job.needed       = needed_r;
    push_job.grow_amt     = ffba_pkg::ru_page(needed_r + 34'(ffba_pkg::HEADER_BYTES));
    push_job.zero         = zero_r;
    push_job.big          = big_r;
    push_job.free_address = faddr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r <= 1'b0;
    end else begin
      st_v_r <= st_v_nxt;
    end
    if (accept) begin
      cmd_r    <= in_item.command;
      needed_r <= needed;
      zero_r   <= (sz == 34'd0);
      big_r    <= (needed[33:32] != 2'b00);
      faddr_r  <= in_item.free_address;
    end
  end

endmodule

// ----- rtl/ffba_queue.sv -----
// Two-entry queue of classified requests between front and back.
// Depends on ffba_pkg.
module ffba_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ffba_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output ffba_pkg::job_t pop_job
);

  ffba_pkg::job_t slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign pop_job = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue push while full");
  assert property (@(posedge clk) disable iff (!rst_n) !(pop && !valid))
    else $error("queue pop while empty");

endmodule

// ----- rtl/ffba_back.sv -----
// Back part: walks the block table and carries out allocate, free and init.
// Depends on ffba_pkg and ffba_ram; fed by ffba_queue.
module ffba_back #(
  parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  ffba_pkg::job_t      q_job,
  output logic                pop,
  input  logic [31:0]         cfg_start,
  input  logic [31:0]         cfg_bytes,
  output logic                out_valid,
  output ffba_pkg::out_item_t out_item
);

  localparam int IW = $clog2(MAX_BLOCKS);

  typedef struct packed {
    logic [31:0]   start;
    logic [31:0]   size;
    logic          free;
    logic [IW-1:0] next;
    logic [IW-1:0] prev;
  } ent_t;

  localparam int EW = $bits(ent_t);
  localparam logic [IW-1:0] LAST = IW'(MAX_BLOCKS - 1);
  localparam logic [33:0] HDR  = 34'(ffba_pkg::HEADER_BYTES);
  localparam logic [34:0] HMIN =
    35'(ffba_pkg::HEADER_BYTES + ffba_pkg::MIN_REMAINDER_BYTES);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_INIT_WR = 5'd1;
  localparam logic [4:0] S_RD      = 5'd2;
  localparam logic [4:0] S_CHK     = 5'd3;
  localparam logic [4:0] S_GRW     = 5'd4;
  localparam logic [4:0] S_GRW2    = 5'd5;
  localparam logic [4:0] S_GRW3    = 5'd6;
  localparam logic [4:0] S_SPL1    = 5'd7;
  localparam logic [4:0] S_SPL2    = 5'd8;
  localparam logic [4:0] S_SPL3    = 5'd9;
  localparam logic [4:0] S_SPL4    = 5'd10;
  localparam logic [4:0] S_FR1     = 5'd11;
  localparam logic [4:0] S_FR2     = 5'd12;
  localparam logic [4:0] S_FR3     = 5'd13;
  localparam logic [4:0] S_FR4     = 5'd14;
  localparam logic [4:0] S_FR5     = 5'd15;
  localparam logic [4:0] S_FR6     = 5'd16;
  localparam logic [4:0] S_FR7     = 5'd17;

  logic [4:0]      state_r, state_nxt;
  ffba_pkg::job_t  job_r, job_nxt;
  logic [IW-1:0]   idx_r, idx_nxt, n_r, n_nxt, j_r, j_nxt, aux_r, aux_nxt;
  logic [IW-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic            pass_r, pass_nxt, ext_r, ext_nxt, skip_r, skip_nxt;
  logic            ready_r, ready_nxt;
  ent_t            ea_r, ea_nxt, eb_r, eb_nxt;
  logic [32:0]     base_r, base_nxt;
  logic [33:0]     naddr_r, naddr_nxt;
  logic [31:0]     used_r, used_nxt, gp_r, gp_nxt, rend_r, rend_nxt;
  logic [MAX_BLOCKS-1:0] used_slot_r, used_slot_nxt;
  logic            out_valid_r, out_valid_nxt;
  ffba_pkg::out_item_t out_item_r, out_item_nxt;

  logic            rd_en, wr_en;
  logic [IW-1:0]   rd_addr, wr_addr;
  ent_t            wr_ent, rd_ent;
  logic [EW-1:0]   rdata;
  logic            free_found;
  logic [IW-1:0]   free_j;

  logic [33:0] base34, endv, data34, used34, amt;
  logic        hit, skip;

  ffba_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_ent),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign rd_ent    = ent_t'(rdata);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    free_found = 1'b0;
    free_j     = '0;
    for (int k = MAX_BLOCKS - 1; k >= 0; k--) begin
      if (!used_slot_r[k]) begin
        free_found = 1'b1;
        free_j     = IW'(k);
      end
    end
  end

  function automatic ffba_pkg::out_item_t mk_out(logic [31:0] a, logic [2:0] s);
    ffba_pkg::out_item_t o;
    o.data_address = a;
    o.status       = s;
    return o;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    aux_nxt       = aux_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    pass_nxt      = pass_r;
    ext_nxt       = ext_r;
    skip_nxt      = skip_r;
    ready_nxt     = ready_r;
    ea_nxt        = ea_r;
    eb_nxt        = eb_r;
    base_nxt      = base_r;
    naddr_nxt     = naddr_r;
    used_nxt      = used_r;
    gp_nxt        = gp_r;
    rend_nxt      = rend_r;
    used_slot_nxt = used_slot_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    pop           = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_ent        = '0;
    base34        = '0;
    endv          = '0;
    data34        = '0;
    used34        = '0;
    amt           = job_r.grow_amt;
    hit           = 1'b0;
    skip          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          pop     = 1'b1;
          job_nxt = q_job;
          idx_nxt = head_r;
          n_nxt   = '0;
          pass_nxt = 1'b0;
          if (q_job.command == ffba_pkg::CMD_INIT) begin
            base34        = ffba_pkg::ru_align({2'b00, cfg_start});
            used_slot_nxt = '0;
            head_nxt      = '0;
            tail_nxt      = '0;
            ready_nxt     = 1'b0;
            rend_nxt      = cfg_start + cfg_bytes;
            base_nxt      = base34[32:0];
            if (base34[33:32] != 2'b00) begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = mk_out(32'd0, ffba_pkg::ST_SPACE);
            end else begin
              state_nxt = S_INIT_WR;
            end
          end else if (!ready_r) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = mk_out(32'd0, ffba_pkg::ST_INVALID);
          end else if (q_job.command == ffba_pkg::CMD_FREE) begin
            if (q_job.free_address == 32'd0) begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = mk_out(32'd0, ffba_pkg::ST_INVALID);
            end else begin
              state_nxt = S_RD;
            end
          end else if (q_job.zero) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = mk_out(32'd0, ffba_pkg::ST_ZERO);
          end else if (q_job.big) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = mk_out(32'd0, ffba_pkg::ST_SPACE);
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_INIT_WR: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if ((base_r[31:0] > rend_r) ||
            (ffba_pkg::INIT_AMT > {2'b00, rend_r - base_r[31:0]})) begin
          out_item_nxt = mk_out(32'd0, ffba_pkg::ST_SPACE);
        end else begin
          wr_en         = 1'b1;
          wr_addr       = '0;
          wr_ent.start  = base_r[31:0];
          wr_ent.size   = 32'(ffba_pkg::INIT_AMT - HDR);
          wr_ent.free   = 1'b1;
          wr_ent.next   = '0;
          wr_ent.prev   = '0;
          used_slot_nxt[0] = 1'b1;
          gp_nxt        = base_r[31:0] + ffba_pkg::INIT_AMT[31:0];
          ready_nxt     = 1'b1;
          out_item_nxt  = mk_out(32'd0, ffba_pkg::ST_OK);
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (job_r.command == ffba_pkg::CMD_FREE) begin
          hit = ((rd_ent.start + HDR[31:0]) == job_r.free_address);
        end else begin
          hit = rd_ent.free && ({2'b00, rd_ent.size} >= job_r.needed);
        end
        if (hit) begin
          ea_nxt = rd_ent;
          if (job_r.command == ffba_pkg::CMD_FREE) begin
            ea_nxt.free = 1'b1;
            state_nxt   = S_FR1;
          end else begin
            state_nxt = S_SPL1;
          end
        end else if ((idx_r == tail_r) || (n_r == LAST)) begin
          if (job_r.command == ffba_pkg::CMD_FREE) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            out_item_nxt  = mk_out(32'd0, ffba_pkg::ST_INVALID);
          end else if (pass_r) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            out_item_nxt  = mk_out(32'd0, ffba_pkg::ST_SPACE);
          end else begin
            rd_en     = 1'b1;
            rd_addr   = tail_r;
            state_nxt = S_GRW;
          end
        end else begin
          idx_nxt   = rd_ent.next;
          n_nxt     = n_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_GRW: begin
        eb_nxt  = rd_ent;
        endv    = {2'b00, rd_ent.start} + HDR + {2'b00, rd_ent.size};
        ext_nxt = rd_ent.free && (endv == {2'b00, gp_r});
        base34  = ffba_pkg::ru_align({2'b00, gp_r});
        base_nxt = ext_nxt ? {1'b0, gp_r} : base34[32:0];
        state_nxt = S_GRW2;
      end
      S_GRW2: begin
        idx_nxt  = head_r;
        n_nxt    = '0;
        pass_nxt = 1'b1;
        if ((base_r > {1'b0, rend_r}) ||
            (amt > {2'b00, rend_r - base_r[31:0]})) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_item_nxt  = mk_out(32'd0, ffba_pkg::ST_SPACE);
        end else if (ext_r) begin
          wr_en       = 1'b1;
          wr_addr     = tail_r;
          wr_ent      = eb_r;
          wr_ent.size = eb_r.size + amt[31:0];
          gp_nxt      = base_r[31:0] + amt[31:0];
          state_nxt   = S_RD;
        end else if (!free_found) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_item_nxt  = mk_out(32'd0, ffba_pkg::ST_FULL);
        end else begin
          wr_en        = 1'b1;
          wr_addr      = free_j;
          wr_ent.start = base_r[31:0];
          wr_ent.size  = 32'(amt - HDR);
          wr_ent.free  = 1'b1;
          wr_ent.next  = free_j;
          wr_ent.prev  = tail_r;
          used_slot_nxt[free_j] = 1'b1;
          j_nxt        = free_j;
          aux_nxt      = tail_r;
          tail_nxt     = free_j;
          gp_nxt       = base_r[31:0] + amt[31:0];
          state_nxt    = S_GRW3;
        end
      end
      S_GRW3: begin
        wr_en       = 1'b1;
        wr_addr     = aux_r;
        wr_ent      = eb_r;
        wr_ent.next = j_r;
        state_nxt   = S_RD;
      end
      S_SPL1: begin
        skip_nxt  = ({3'b000, ea_r.size} < ({1'b0, job_r.needed} + HMIN));
        naddr_nxt = ffba_pkg::ru_align({2'b00, ea_r.start} + HDR + job_r.needed);
        state_nxt = S_SPL2;
      end
      S_SPL2: begin
        data34 = {2'b00, ea_r.start} + HDR;
        used34 = naddr_r - data34;
        skip   = skip_r || ({1'b0, naddr_r} + {1'b0, HDR} > {3'b000, rend_r}) ||
                 ({3'b000, ea_r.size} < ({1'b0, used34} + HMIN)) || !free_found;
        used_nxt = used34[31:0];
        if (skip) begin
          wr_en         = 1'b1;
          wr_addr       = idx_r;
          wr_ent        = ea_r;
          wr_ent.free   = 1'b0;
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_item_nxt  = mk_out(data34[31:0], ffba_pkg::ST_OK);
        end else begin
          wr_en        = 1'b1;
          wr_addr      = free_j;
          wr_ent.start = naddr_r[31:0];
          wr_ent.size  = ea_r.size - used34[31:0] - HDR[31:0];
          wr_ent.free  = 1'b1;
          wr_ent.prev  = idx_r;
          wr_ent.next  = (idx_r == tail_r) ? free_j : ea_r.next;
          used_slot_nxt[free_j] = 1'b1;
          j_nxt        = free_j;
          if (idx_r == tail_r) begin
            tail_nxt  = free_j;
            state_nxt = S_SPL4;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = ea_r.next;
            state_nxt = S_SPL3;
          end
        end
      end
      S_SPL3: begin
        wr_en       = 1'b1;
        wr_addr     = ea_r.next;
        wr_ent      = rd_ent;
        wr_ent.prev = j_r;
        state_nxt   = S_SPL4;
      end
      S_SPL4: begin
        wr_en         = 1'b1;
        wr_addr       = idx_r;
        wr_ent        = ea_r;
        wr_ent.next   = j_r;
        wr_ent.size   = used_r;
        wr_ent.free   = 1'b0;
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_item_nxt  = mk_out(ea_r.start + HDR[31:0], ffba_pkg::ST_OK);
      end
      S_FR1: begin
        if (idx_r != tail_r) begin
          rd_en     = 1'b1;
          rd_addr   = ea_r.next;
          state_nxt = S_FR2;
        end else begin
          state_nxt = S_FR4;
        end
      end
      S_FR2: begin
        endv      = {2'b00, ea_r.start} + HDR + {2'b00, ea_r.size};
        state_nxt = S_FR4;
        if (rd_ent.free && (endv == {2'b00, rd_ent.start})) begin
          ea_nxt.size = ea_r.size + HDR[31:0] + rd_ent.size;
          used_slot_nxt[ea_r.next] = 1'b0;
          if (ea_r.next == tail_r) begin
            tail_nxt    = idx_r;
            ea_nxt.next = idx_r;
          end else begin
            ea_nxt.next = rd_ent.next;
            rd_en       = 1'b1;
            rd_addr     = rd_ent.next;
            state_nxt   = S_FR3;
          end
        end
      end
      S_FR3: begin
        wr_en       = 1'b1;
        wr_addr     = ea_r.next;
        wr_ent      = rd_ent;
        wr_ent.prev = idx_r;
        state_nxt   = S_FR4;
      end
      S_FR4: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_ent  = ea_r;
        if (idx_r != head_r) begin
          rd_en     = 1'b1;
          rd_addr   = ea_r.prev;
          state_nxt = S_FR5;
        end else begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_item_nxt  = mk_out(32'd0, ffba_pkg::ST_OK);
        end
      end
      S_FR5: begin
        endv = {2'b00, rd_ent.start} + HDR + {2'b00, rd_ent.size};
        if (rd_ent.free && (endv == {2'b00, ea_r.start})) begin
          eb_nxt      = rd_ent;
          eb_nxt.size = rd_ent.size + HDR[31:0] + ea_r.size;
          used_slot_nxt[idx_r] = 1'b0;
          if (idx_r == tail_r) begin
            tail_nxt    = ea_r.prev;
            eb_nxt.next = ea_r.prev;
            state_nxt   = S_FR7;
          end else begin
            eb_nxt.next = ea_r.next;
            rd_en       = 1'b1;
            rd_addr     = ea_r.next;
            state_nxt   = S_FR6;
          end
        end else begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_item_nxt  = mk_out(32'd0, ffba_pkg::ST_OK);
        end
      end
      S_FR6: begin
        wr_en       = 1'b1;
        wr_addr     = ea_r.next;
        wr_ent      = rd_ent;
        wr_ent.prev = ea_r.prev;
        state_nxt   = S_FR7;
      end
      S_FR7: begin
        wr_en         = 1'b1;
        wr_addr       = ea_r.prev;
        wr_ent        = eb_r;
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_item_nxt  = mk_out(32'd0, ffba_pkg::ST_OK);
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      gp_r        <= '0;
      rend_r      <= '0;
      ready_r     <= 1'b0;
      used_slot_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      gp_r        <= gp_nxt;
      rend_r      <= rend_nxt;
      ready_r     <= ready_nxt;
      used_slot_r <= used_slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r      <= job_nxt;
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    j_r        <= j_nxt;
    aux_r      <= aux_nxt;
    pass_r     <= pass_nxt;
    ext_r      <= ext_nxt;
    skip_r     <= skip_nxt;
    ea_r       <= ea_nxt;
    eb_r       <= eb_nxt;
    base_r     <= base_nxt;
    naddr_r    <= naddr_nxt;
    used_r     <= used_nxt;
    out_item_r <= out_item_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_valid_r |-> state_r == S_IDLE)
    else $error("result outside idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.status != ffba_pkg::ST_OK |-> out_item_r.data_address == 32'd0)
    else $error("failed request with nonzero address");
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ready_r) |-> $past(state_r) == S_INIT_WR)
    else $error("ready set outside init");
  assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> used_slot_r[head_r] && used_slot_r[tail_r])
    else $error("head or tail slot not in use");
  assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && wr_en |-> rd_addr != wr_addr)
    else $error("table read and write collide");

endmodule
